// File: rtl/core/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the suspendable countdown timer core.
// ----------------------------------------------------------------------------
package sct_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int OPCODE_W = 2;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // sound scheduling thresholds and periods in ms
    localparam logic [TIME_W-1:0] NORMAL_THRESHOLD_MS = 32'd6000;
    localparam logic [TIME_W-1:0] FAST_THRESHOLD_MS   = 32'd2000;
    localparam logic [TIME_W-1:0] SLOW_PERIOD_MS      = 32'd1000;
    localparam logic [TIME_W-1:0] FAST_PERIOD_MS      = 32'd250;

    // item opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_START       = 2'd0,
        OP_TICK        = 2'd1,
        OP_SET_SUSPEND = 2'd2,
        OP_MAP_SUSPEND = 2'd3
    } opcode_t;

    // sound reported by a tick
    typedef enum logic [KIND_W-1:0] {
        SOUND_NONE   = 2'd0,
        SOUND_NORMAL = 2'd1,
        SOUND_HURRY  = 2'd2
    } sound_kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_MS           = 2'd0,
        CFG_SOUND_ENABLED      = 2'd1,
        CFG_FOLLOW_MAP_SUSPEND = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] delay_ms;
        logic              sound_enabled;
        logic              follow_map_suspend;
    } cfg_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [TIME_W-1:0] now_ms;
        logic              flag;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] expiry_time;
        logic [TIME_W-1:0] next_sound_time;
        logic [TIME_W-1:0] suspend_time;
        logic              done_flag;
        logic              paused_flag;
        logic              sound_armed;
    } timer_state_t;

    typedef struct packed {
        logic        finished;
        logic        suspended;
        sound_kind_t sound_kind;
    } result_t;

endpackage

// File: rtl/core/sct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_req_if / sct_rsp_if
// Valid/ready channels for timer events and timer status results.
// ----------------------------------------------------------------------------
interface sct_req_if;
    logic                        valid;
    logic                        ready;
    logic [sct_pkg::OPCODE_W-1:0] opcode;
    logic [sct_pkg::TIME_W-1:0]   now_ms;
    logic                        flag;

    modport source (output valid, output opcode, output now_ms, output flag, input ready);
    modport sink   (input valid, input opcode, input now_ms, input flag, output ready);
endinterface

interface sct_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       finished;
    logic                       suspended;
    logic [sct_pkg::KIND_W-1:0] sound_kind;

    modport source (output valid, output finished, output suspended, output sound_kind,
                    input ready);
    modport sink   (input valid, input finished, input suspended, input sound_kind,
                    output ready);
endinterface

// File: rtl/core/suspendable_countdown_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suspendable_countdown_timer_core
// Millisecond countdown timer with suspend/resume and clock sound scheduling.
// ----------------------------------------------------------------------------
// The core takes one event per clock while the result side is not stalled
// and returns exactly one status result per event, registered in the result
// register. An event lands in an input register, its effect on the timer
// state and its status are computed in one pass of compare/add logic, and
// the status is held in a result register. The timer state updates in the
// same cycle as the result register, so the next event sees it at once.
// A stalled result side holds the pipeline; the input register keeps taking
// one more event while a finished result waits. Configuration is taken at
// any cycle through cfg_wr_en/cfg_index/cfg_data and applies to later events.
// ----------------------------------------------------------------------------
module suspendable_countdown_timer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sct_pkg::CFG_DATA_W-1:0]  cfg_data,
    sct_req_if.sink                         req,
    sct_rsp_if.source                       rsp
);
    import sct_pkg::*;

    cfg_t         cfg;
    item_t        item_reg;
    logic         item_valid_reg;
    logic         item_valid_next;
    timer_state_t state_reg;
    timer_state_t state_next;
    result_t      result_reg;
    result_t      step_result;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    logic         advance;
    logic         req_xfer;

    // configuration registers
    sct_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // event evaluation
    sct_step_logic u_step_logic (
        .cfg       (cfg),
        .item      (item_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (step_result)
    );

    // flow control: the result register frees up when empty or taken
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !item_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    assign item_valid_next = req_xfer || (item_valid_reg && !advance);
    assign rsp_valid_next  = (item_valid_reg && advance) || (rsp_valid_reg && !rsp.ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (item_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            item_reg.opcode <= opcode_t'(req.opcode);
            item_reg.now_ms <= req.now_ms;
            item_reg.flag   <= req.flag;
        end
        if (item_valid_reg && advance)
        begin
            result_reg <= step_result;
        end
    end

    // result channel
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.finished   = result_reg.finished;
    assign rsp.suspended  = result_reg.suspended;
    assign rsp.sound_kind = result_reg.sound_kind;

endmodule

// File: rtl/core/sct_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_cfg_regs
// Configuration register file written through a plain index/data port.
// ----------------------------------------------------------------------------
module sct_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sct_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sct_pkg::cfg_t                   cfg
);
    import sct_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DELAY_MS:           cfg_next.delay_ms = cfg_data[TIME_W-1:0];
                CFG_SOUND_ENABLED:      cfg_next.sound_enabled = cfg_data[0];
                CFG_FOLLOW_MAP_SUSPEND: cfg_next.follow_map_suspend = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/sct_step_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_step_logic
// Next-state and status computation for one timer event.
// ----------------------------------------------------------------------------
module sct_step_logic (
    input  sct_pkg::cfg_t         cfg,
    input  sct_pkg::item_t        item,
    input  sct_pkg::timer_state_t state_cur,
    output sct_pkg::timer_state_t state_nxt,
    output sct_pkg::result_t      result
);
    import sct_pkg::*;

    logic              do_suspend_op;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] remaining;
    logic              now_past_expiry;
    logic              sound_due;
    sound_kind_t       kind;

    // shared arithmetic
    assign gap             = item.now_ms - state_cur.suspend_time;
    assign remaining       = state_cur.expiry_time - item.now_ms;
    assign now_past_expiry = (item.now_ms >= state_cur.expiry_time);
    assign sound_due       = state_cur.sound_armed && (item.now_ms >= state_cur.next_sound_time);

    // a map suspend request only counts when following is enabled; resume always does
    assign do_suspend_op = (item.opcode == OP_SET_SUSPEND) ||
                           ((item.opcode == OP_MAP_SUSPEND) &&
                            (cfg.follow_map_suspend || !item.flag));

    // event decode
    always_comb
    begin
        state_nxt = state_cur;
        kind      = SOUND_NONE;
        unique case (item.opcode)
            OP_START:
            begin
                state_nxt.done_flag       = 1'b0;
                state_nxt.paused_flag     = 1'b0;
                state_nxt.suspend_time    = '0;
                state_nxt.expiry_time     = item.now_ms + cfg.delay_ms;
                state_nxt.sound_armed     = cfg.sound_enabled;
                state_nxt.next_sound_time = cfg.sound_enabled ? item.now_ms : '0;
            end
            OP_TICK:
            begin
                if (!state_cur.paused_flag && !state_cur.done_flag)
                begin
                    state_nxt.done_flag = now_past_expiry;
                    if (sound_due)
                    begin
                        kind = (remaining > NORMAL_THRESHOLD_MS) ? SOUND_NORMAL : SOUND_HURRY;
                        state_nxt.next_sound_time = state_cur.next_sound_time +
                            ((remaining > FAST_THRESHOLD_MS) ? SLOW_PERIOD_MS : FAST_PERIOD_MS);
                    end
                end
            end
            OP_SET_SUSPEND, OP_MAP_SUSPEND:
            begin
                if (do_suspend_op && (item.flag != state_cur.paused_flag))
                begin
                    state_nxt.paused_flag = item.flag;
                    if (item.flag)
                    begin
                        state_nxt.suspend_time = item.now_ms;
                    end
                    // suspension that began at time zero adds no shift
                    else if (state_cur.suspend_time != '0)
                    begin
                        state_nxt.expiry_time = state_cur.expiry_time + gap;
                        if (state_cur.sound_armed)
                        begin
                            state_nxt.next_sound_time = state_cur.next_sound_time + gap;
                        end
                    end
                end
            end
            default:
            begin
                state_nxt = state_cur;
            end
        endcase
    end

    // status after the event
    assign result.finished   = state_nxt.done_flag;
    assign result.suspended  = state_nxt.paused_flag;
    assign result.sound_kind = kind;

endmodule
